>>> design/phd_pkg.sv
// shared types, constants and coefficient tables of the phase difference block
`default_nettype none
package phd_pkg;

    localparam int POINTS      = 20;
    localparam int POS_W       = $clog2(POINTS);
    localparam int RAW_W       = 16;
    localparam int SMP_W       = 12;
    localparam int BIN_W       = 24;
    localparam int DVS_W       = 12;
    localparam int QUO_W       = 15;
    localparam int TOT_W       = 20;
    localparam int VAL_W       = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = VAL_W + COEF_W;
    localparam int ACC_W       = 36;
    localparam int CORD_W      = 60;
    localparam int ANG_W       = 32;
    localparam int CSTEP_W     = 5;
    localparam int DSTEP_W     = 5;
    localparam int PRESCALE_SH = 20;
    localparam int TENTHS_W    = 12;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    // mean of the bins: total * ceil(2^24 / 20) >> 24, exact for totals below 2^22
    localparam int MEAN_SH     = 24;

    localparam logic [BIN_W-1:0]  BIN_LIMIT     = BIN_W'(4095 * 4096);
    localparam logic [BIN_W-1:0]  QUO_LIMIT     = BIN_W'(32767);
    localparam logic [DVS_W-1:0]  DIVISOR_RESET = DVS_W'(20);
    localparam logic [TOT_W-1:0]  MEAN_RECIP    = TOT_W'(838861);
    localparam logic [ANG_W-1:0]  HALF_TURN     = 32'h8000_0000;
    localparam logic [ANG_W-1:0]  QUARTER_TURN  = 32'h4000_0000;
    localparam logic [ANG_W-1:0]  THREE_QUARTER = 32'hC000_0000;

    typedef struct packed {
        logic [SMP_W-1:0] sample_a;
        logic [SMP_W-1:0] sample_b;
        logic             last;
    } q_entry_t;

    function automatic logic signed [COEF_W-1:0] cos_q14(input logic [POS_W-1:0] i);
        logic signed [COEF_W-1:0] r;
        case (i)
            5'd0:  r = 16'sd16384;
            5'd1:  r = 16'sd15582;
            5'd2:  r = 16'sd13255;
            5'd3:  r = 16'sd9630;
            5'd4:  r = 16'sd5063;
            5'd5:  r = 16'sd0;
            5'd6:  r = -16'sd5063;
            5'd7:  r = -16'sd9630;
            5'd8:  r = -16'sd13255;
            5'd9:  r = -16'sd15582;
            5'd10: r = -16'sd16384;
            5'd11: r = -16'sd15582;
            5'd12: r = -16'sd13255;
            5'd13: r = -16'sd9630;
            5'd14: r = -16'sd5063;
            5'd15: r = 16'sd0;
            5'd16: r = 16'sd5063;
            5'd17: r = 16'sd9630;
            5'd18: r = 16'sd13255;
            5'd19: r = 16'sd15582;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [COEF_W-1:0] sin_q14(input logic [POS_W-1:0] i);
        logic signed [COEF_W-1:0] r;
        case (i)
            5'd0:  r = 16'sd0;
            5'd1:  r = 16'sd5063;
            5'd2:  r = 16'sd9630;
            5'd3:  r = 16'sd13255;
            5'd4:  r = 16'sd15582;
            5'd5:  r = 16'sd16384;
            5'd6:  r = 16'sd15582;
            5'd7:  r = 16'sd13255;
            5'd8:  r = 16'sd9630;
            5'd9:  r = 16'sd5063;
            5'd10: r = 16'sd0;
            5'd11: r = -16'sd5063;
            5'd12: r = -16'sd9630;
            5'd13: r = -16'sd13255;
            5'd14: r = -16'sd15582;
            5'd15: r = -16'sd16384;
            5'd16: r = -16'sd15582;
            5'd17: r = -16'sd13255;
            5'd18: r = -16'sd9630;
            5'd19: r = -16'sd5063;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [ANG_W-1:0] atan_turn(input logic [CSTEP_W-1:0] i);
        logic [ANG_W-1:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003;
            5'd29: r = 32'h00000001;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/two_channel_phase_difference_top.sv
// top level of the two-channel phase difference detector
`default_nettype none
// Sample pairs (low 12 bits of each word) are accumulated into 20 phase bins
// per channel at one transfer per clock; a four-entry queue sits between the
// input stage and the accumulator. The transfer flagged last_sample closes
// the capture and starts evaluation, during which the accumulator takes no
// new samples (the input stage and queue still absorb five transfers): each
// bin is divided by the configured divisor with a serial divider, the
// channel mean comes from a reciprocal multiply, the DFT sums are formed and
// a 32-step CORDIC gives each channel's angle; the result is registered once
// the result register is free. Results leave through a registered
// valid/ready port.
module two_channel_phase_difference_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [phd_pkg::DVS_W-1:0]            cfg_data,
    // sample transfers
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [phd_pkg::RAW_W-1:0]            s_sample_a,
    input  wire logic [phd_pkg::RAW_W-1:0]            s_sample_b,
    input  wire logic                                 s_last_sample,
    // result transfers
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [phd_pkg::TENTHS_W-1:0]       m_phase_tenths,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_max_a,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_min_a,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_max_b,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_min_b,
    output logic                                      m_capture_short
);
    import phd_pkg::*;

    logic [DVS_W-1:0] divisor_reg;
    logic [DVS_W-1:0] divisor_eff;
    logic             push, push_ready, pop, pop_valid;
    q_entry_t         push_entry, pop_entry;

    // divisor register, always writable; zero behaves as one
    assign cfg_ready   = 1'b1;
    assign divisor_eff = (divisor_reg == '0) ? DVS_W'(1) : divisor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= DIVISOR_RESET;
        end else if (cfg_valid) begin
            divisor_reg <= cfg_data;
        end
    end

    // input stage
    phd_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_sample_a(s_sample_a), .s_sample_b(s_sample_b), .s_last_sample(s_last_sample),
        .push(push), .push_entry(push_entry), .push_ready(push_ready)
    );

    // decoupling queue
    phd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(push), .push_entry(push_entry), .push_ready(push_ready),
        .pop_valid(pop_valid), .pop_entry(pop_entry), .pop(pop)
    );

    // accumulation and evaluation
    phd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .divisor(divisor_eff),
        .pop_valid(pop_valid), .pop_entry(pop_entry), .pop(pop),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_phase_tenths(m_phase_tenths),
        .m_peak_max_a(m_peak_max_a), .m_peak_min_a(m_peak_min_a),
        .m_peak_max_b(m_peak_max_b), .m_peak_min_b(m_peak_min_b),
        .m_capture_short(m_capture_short)
    );

endmodule
`default_nettype wire

>>> design/phd_front.sv
// input stage: takes sample transfers, keeps the low bits and queues them
`default_nettype none
module phd_front (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [phd_pkg::RAW_W-1:0]   s_sample_a,
    input  wire logic [phd_pkg::RAW_W-1:0]   s_sample_b,
    input  wire logic                        s_last_sample,
    output logic                             push,
    output phd_pkg::q_entry_t                push_entry,
    input  wire logic                        push_ready
);
    import phd_pkg::*;

    logic     valid_reg;
    q_entry_t entry_reg;

    assign s_ready    = !valid_reg || push_ready;
    assign push       = valid_reg;
    assign push_entry = entry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            entry_reg.sample_a <= s_sample_a[SMP_W-1:0];
            entry_reg.sample_b <= s_sample_b[SMP_W-1:0];
            entry_reg.last     <= s_last_sample;
        end
    end

endmodule
`default_nettype wire

>>> design/phd_fifo.sv
// short queue between the input stage and the evaluation engine
`default_nettype none
module phd_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire phd_pkg::q_entry_t  push_entry,
    output logic                    push_ready,
    output logic                    pop_valid,
    output phd_pkg::q_entry_t       pop_entry,
    input  wire logic               pop
);
    import phd_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != (QPTR_W+1)'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!do_push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

>>> design/phd_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module phd_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [phd_pkg::BIN_W-1:0]  dividend,
    input  wire logic [phd_pkg::DVS_W-1:0]  divisor,
    output logic                            done,
    output logic [phd_pkg::BIN_W-1:0]       quotient
);
    import phd_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DSTEP_W-1:0]  step_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [BIN_W-1:0]    quo_reg;
    logic [DVS_W:0]      trial;
    logic                fits;

    assign trial    = {rem_reg, quo_reg[BIN_W-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == DSTEP_W'(BIN_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? DVS_W'(trial - {1'b0, divisor}) : trial[DVS_W-1:0];
            quo_reg <= {quo_reg[BIN_W-2:0], fits};
        end
    end

endmodule
`default_nettype wire

>>> design/phd_cordic.sv
// vectoring cordic giving the angle of (sine sum, cosine sum) in binary turns
`default_nettype none
module phd_cordic (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic signed [phd_pkg::ACC_W-1:0]  c_in,
    input  wire logic signed [phd_pkg::ACC_W-1:0]  s_in,
    output logic                                   done,
    output logic [phd_pkg::ANG_W-1:0]              angle
);
    import phd_pkg::*;

    logic                      busy_reg;
    logic                      done_reg;
    logic [CSTEP_W-1:0]        step_reg;
    logic signed [CORD_W-1:0]  x_reg;
    logic signed [CORD_W-1:0]  y_reg;
    logic [ANG_W-1:0]          z_reg;
    logic signed [CORD_W-1:0]  x0;
    logic signed [CORD_W-1:0]  y0;
    logic signed [CORD_W-1:0]  xs;
    logic signed [CORD_W-1:0]  ys;
    logic                      axis;
    logic [ANG_W-1:0]          axis_angle;

    always_comb begin
        x0 = CORD_W'(s_in) <<< PRESCALE_SH;
        y0 = CORD_W'(c_in) <<< PRESCALE_SH;
        if (s_in < 0) begin
            x0 = -x0;
            y0 = -y0;
        end
        axis       = (c_in == '0) || (s_in == '0);
        if (c_in == '0) begin
            axis_angle = (s_in >= 0) ? '0 : HALF_TURN;
        end else begin
            axis_angle = (c_in > 0) ? QUARTER_TURN : THREE_QUARTER;
        end
        xs = x_reg >>> step_reg;
        ys = y_reg >>> step_reg;
    end

    assign done  = done_reg;
    assign angle = z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= !axis;
            done_reg <= axis;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == '1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        if (start) begin
            x_reg <= x0;
            y_reg <= y0;
            z_reg <= axis ? axis_angle : ((s_in < 0) ? HALF_TURN : '0);
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_turn(step_reg);
            end else begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_turn(step_reg);
            end
        end
    end

endmodule
`default_nettype wire

>>> design/phd_back.sv
// bin accumulation and end-of-capture evaluation sequencer with result register
`default_nettype none
module phd_back (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [phd_pkg::DVS_W-1:0]            divisor,
    input  wire logic                                 pop_valid,
    input  wire phd_pkg::q_entry_t                    pop_entry,
    output logic                                      pop,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic signed [phd_pkg::TENTHS_W-1:0]       m_phase_tenths,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_max_a,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_min_a,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_max_b,
    output logic signed [phd_pkg::VAL_W-1:0]          m_peak_min_b,
    output logic                                      m_capture_short
);
    import phd_pkg::*;

    typedef enum logic [2:0] {
        ST_ACC, ST_DIV, ST_TOT, ST_MAC, ST_CORD, ST_PH1, ST_PH2
    } state_t;

    state_t                    state_reg;
    logic [BIN_W-1:0]          bins_a_reg [POINTS];
    logic [BIN_W-1:0]          bins_b_reg [POINTS];
    logic [QUO_W-1:0]          q_a_reg [POINTS];
    logic [QUO_W-1:0]          q_b_reg [POINTS];
    logic [POS_W-1:0]          pos_reg;
    logic [POS_W-1:0]          seen_reg;
    logic [POS_W-1:0]          idx_reg;
    logic                      start_reg;
    logic                      phase_reg;
    logic                      short_reg;
    logic [TOT_W-1:0]          tot_a_reg, tot_b_reg;
    logic [QUO_W-1:0]          off_a_reg, off_b_reg;
    logic signed [VAL_W-1:0]   max_a_reg, min_a_reg, max_b_reg, min_b_reg;
    logic signed [PROD_W-1:0]  pca_reg, psa_reg, pcb_reg, psb_reg;
    logic signed [ACC_W-1:0]   ca_reg, sa_reg, cb_reg, sb_reg;
    logic                      neg_reg, half_reg;
    logic [43:0]               prod_reg;
    logic                      m_valid_reg;

    logic [BIN_W:0]            sum_a, sum_b;
    logic [BIN_W-1:0]          dvd_a, dvd_b;
    logic [BIN_W-1:0]          quo_a, quo_b;
    logic                      dn_a, dn_b, cd_a, cd_b;
    logic [ANG_W-1:0]          za, zb, dturn, mag;
    logic [QUO_W-1:0]          sat_a, sat_b;
    logic [2*TOT_W-1:0]        mean_a, mean_b;
    logic signed [VAL_W-1:0]   va, vb;
    logic [43:0]               rnd;
    logic [10:0]               r;
    logic                      out_free;

    assign sum_a    = {1'b0, bins_a_reg[pos_reg]} + (BIN_W+1)'(pop_entry.sample_a);
    assign sum_b    = {1'b0, bins_b_reg[pos_reg]} + (BIN_W+1)'(pop_entry.sample_b);
    assign dvd_a    = bins_a_reg[idx_reg];
    assign dvd_b    = bins_b_reg[idx_reg];
    assign sat_a    = (quo_a > QUO_LIMIT) ? '1 : quo_a[QUO_W-1:0];
    assign sat_b    = (quo_b > QUO_LIMIT) ? '1 : quo_b[QUO_W-1:0];
    assign mean_a   = tot_a_reg * MEAN_RECIP;
    assign mean_b   = tot_b_reg * MEAN_RECIP;
    assign va       = VAL_W'($signed({2'b0, q_a_reg[idx_reg]}) - $signed({2'b0, off_a_reg}));
    assign vb       = VAL_W'($signed({2'b0, q_b_reg[idx_reg]}) - $signed({2'b0, off_b_reg}));
    assign dturn    = zb - za;
    assign mag      = dturn[ANG_W-1] ? (~dturn + 1'b1) : dturn;
    assign rnd      = prod_reg + 44'h0_8000_0000;
    assign r        = rnd[42:32];
    assign pop      = (state_reg == ST_ACC) && pop_valid;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    phd_div u_div_a (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg && state_reg == ST_DIV),
        .dividend(dvd_a), .divisor(divisor),
        .done(dn_a), .quotient(quo_a)
    );
    phd_div u_div_b (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg && state_reg == ST_DIV),
        .dividend(dvd_b), .divisor(divisor),
        .done(dn_b), .quotient(quo_b)
    );
    phd_cordic u_cord_a (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg && state_reg == ST_CORD),
        .c_in(ca_reg), .s_in(sa_reg), .done(cd_a), .angle(za)
    );
    phd_cordic u_cord_b (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg && state_reg == ST_CORD),
        .c_in(cb_reg), .s_in(sb_reg), .done(cd_b), .angle(zb)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            pos_reg     <= '0;
            seen_reg    <= '0;
            idx_reg     <= '0;
            start_reg   <= 1'b0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < POINTS; i++) begin
                bins_a_reg[i] <= '0;
                bins_b_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            start_reg <= 1'b0;
            case (state_reg)
                ST_ACC: begin
                    if (pop_valid) begin
                        bins_a_reg[pos_reg] <= (sum_a > {1'b0, BIN_LIMIT}) ?
                                               BIN_LIMIT : sum_a[BIN_W-1:0];
                        bins_b_reg[pos_reg] <= (sum_b > {1'b0, BIN_LIMIT}) ?
                                               BIN_LIMIT : sum_b[BIN_W-1:0];
                        if (pop_entry.last) begin
                            // capture complete: start evaluation, rewind position
                            pos_reg   <= '0;
                            seen_reg  <= '0;
                            short_reg <= seen_reg < POS_W'(POINTS - 1);
                            idx_reg   <= '0;
                            start_reg <= 1'b1;
                            tot_a_reg <= '0;
                            tot_b_reg <= '0;
                            state_reg <= ST_DIV;
                        end else begin
                            pos_reg  <= (pos_reg == POS_W'(POINTS - 1)) ? '0 : pos_reg + 1'b1;
                            if (seen_reg != POS_W'(POINTS)) begin
                                seen_reg <= seen_reg + 1'b1;
                            end
                        end
                    end
                end
                ST_DIV: begin
                    if (start_reg) begin
                        bins_a_reg[idx_reg] <= '0;
                        bins_b_reg[idx_reg] <= '0;
                    end else if (dn_a && dn_b) begin
                        q_a_reg[idx_reg] <= sat_a;
                        q_b_reg[idx_reg] <= sat_b;
                        tot_a_reg <= tot_a_reg + TOT_W'(sat_a);
                        tot_b_reg <= tot_b_reg + TOT_W'(sat_b);
                        if (idx_reg == POS_W'(POINTS - 1)) begin
                            state_reg <= ST_TOT;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_TOT: begin
                    off_a_reg <= mean_a[MEAN_SH +: QUO_W];
                    off_b_reg <= mean_b[MEAN_SH +: QUO_W];
                    idx_reg   <= '0;
                    phase_reg <= 1'b0;
                    max_a_reg <= {1'b1, {(VAL_W-1){1'b0}}};
                    min_a_reg <= {1'b0, {(VAL_W-1){1'b1}}};
                    max_b_reg <= {1'b1, {(VAL_W-1){1'b0}}};
                    min_b_reg <= {1'b0, {(VAL_W-1){1'b1}}};
                    ca_reg    <= '0;
                    sa_reg    <= '0;
                    cb_reg    <= '0;
                    sb_reg    <= '0;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    if (!phase_reg) begin
                        if (va > max_a_reg) max_a_reg <= va;
                        if (va < min_a_reg) min_a_reg <= va;
                        if (vb > max_b_reg) max_b_reg <= vb;
                        if (vb < min_b_reg) min_b_reg <= vb;
                        pca_reg   <= va * cos_q14(idx_reg);
                        psa_reg   <= va * sin_q14(idx_reg);
                        pcb_reg   <= vb * cos_q14(idx_reg);
                        psb_reg   <= vb * sin_q14(idx_reg);
                        phase_reg <= 1'b1;
                    end else begin
                        ca_reg    <= ca_reg + ACC_W'(pca_reg);
                        sa_reg    <= sa_reg + ACC_W'(psa_reg);
                        cb_reg    <= cb_reg + ACC_W'(pcb_reg);
                        sb_reg    <= sb_reg + ACC_W'(psb_reg);
                        phase_reg <= 1'b0;
                        if (idx_reg == POS_W'(POINTS - 1)) begin
                            start_reg <= 1'b1;
                            state_reg <= ST_CORD;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                ST_CORD: begin
                    if (!start_reg && cd_a && cd_b) begin
                        half_reg  <= dturn == HALF_TURN;
                        neg_reg   <= dturn[ANG_W-1];
                        prod_reg  <= 44'(mag[ANG_W-2:0] * 12'd3600);
                        state_reg <= ST_PH1;
                    end
                end
                ST_PH1: begin
                    state_reg <= ST_PH2;
                end
                ST_PH2: begin
                    if (out_free) begin
                        if (half_reg || r == 11'd1800) begin
                            m_phase_tenths <= 12'sd1800;
                        end else if (neg_reg) begin
                            m_phase_tenths <= -$signed({1'b0, r});
                        end else begin
                            m_phase_tenths <= $signed({1'b0, r});
                        end
                        m_peak_max_a    <= max_a_reg;
                        m_peak_min_a    <= min_a_reg;
                        m_peak_max_b    <= max_b_reg;
                        m_peak_min_b    <= min_b_reg;
                        m_capture_short <= short_reg;
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_ACC;
                    end
                end
                default: begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
